// File: design/udp_ipv4_header_parser_defines.svh
// assertion macros shared by the parser rtl
`ifndef UDP_IPV4_HEADER_PARSER_DEFINES_SVH
`define UDP_IPV4_HEADER_PARSER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define UDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true outside reset
`define UDP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: design/udpip_pkg.sv
package udpip_pkg;

  localparam int STORE_DEPTH = 82;
  localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd42;
  localparam logic [6:0] ETH_HDR_LEN = 7'd14;
  localparam logic [6:0] UDP_HDR_LEN = 7'd8;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] ETYPE_HI = 8'h08;
  localparam logic [7:0] ETYPE_LO = 8'h00;
  localparam int UDP_FIELD_BYTES = 6;

  // byte positions in the frame
  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL = 7'd14;
  localparam logic [6:0] POS_PROTO = 7'd23;
  localparam logic [6:0] POS_SA0 = 7'd26;
  localparam logic [6:0] POS_SA1 = 7'd27;
  localparam logic [6:0] POS_SA2 = 7'd28;
  localparam logic [6:0] POS_SA3 = 7'd29;
  localparam logic [6:0] POS_DA0 = 7'd30;
  localparam logic [6:0] POS_DA1 = 7'd31;
  localparam logic [6:0] POS_DA2 = 7'd32;
  localparam logic [6:0] POS_DA3 = 7'd33;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_TRUNC  = 2'd2
  } status_e;

  // classified frame passed from front to back
  typedef struct packed {
    status_e     status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [6:0]  pay_off;
    logic [15:0] udp_len;
  } rec_t;

endpackage

// File: design/udpip_front.sv
module udpip_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        frame_byte_i,
  input  logic              last_byte_i,
  output logic              push_o,
  output udpip_pkg::rec_t   rec_o
);

  logic [15:0] count_q, count_d, len_next;
  logic        pos_ok;
  logic [6:0]  pos, off_cur, rel, off_hdr;
  logic [3:0]  ihl_cur;
  logic        udp_hit, reject, trunc;
  logic [7:0]  et_hi_q, et_lo_q, proto_q;
  logic [3:0]  ihl_q;
  logic [31:0] sa_q, da_q;
  logic [7:0]  udp_q [udpip_pkg::UDP_FIELD_BYTES];

  always_comb begin
    len_next = (count_q < udpip_pkg::MAX_FRAME_BYTES) ? count_q + 16'd1 : count_q;
    count_d  = last_byte_i ? 16'd0 : len_next;
    pos_ok   = count_q < 16'(udpip_pkg::STORE_DEPTH);
    pos      = count_q[6:0];
    // ihl arrives at byte 14, which can itself be the first udp byte
    ihl_cur  = (pos == udpip_pkg::POS_IHL) ? frame_byte_i[3:0] : ihl_q;
    off_cur  = udpip_pkg::ETH_HDR_LEN + {1'b0, ihl_cur, 2'b00};
    rel      = pos - off_cur;
    udp_hit  = pos_ok && (pos >= off_cur) && (rel < 7'(udpip_pkg::UDP_FIELD_BYTES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (acc_i) begin
      count_q <= count_d;
    end
  end

  // header field capture
  always_ff @(posedge clk_i) begin
    if (acc_i && pos_ok) begin
      unique case (pos)
        udpip_pkg::POS_ETYPE_HI: et_hi_q <= frame_byte_i;
        udpip_pkg::POS_ETYPE_LO: et_lo_q <= frame_byte_i;
        udpip_pkg::POS_IHL:      ihl_q <= frame_byte_i[3:0];
        udpip_pkg::POS_PROTO:    proto_q <= frame_byte_i;
        udpip_pkg::POS_SA0:      sa_q[31:24] <= frame_byte_i;
        udpip_pkg::POS_SA1:      sa_q[23:16] <= frame_byte_i;
        udpip_pkg::POS_SA2:      sa_q[15:8] <= frame_byte_i;
        udpip_pkg::POS_SA3:      sa_q[7:0] <= frame_byte_i;
        udpip_pkg::POS_DA0:      da_q[31:24] <= frame_byte_i;
        udpip_pkg::POS_DA1:      da_q[23:16] <= frame_byte_i;
        udpip_pkg::POS_DA2:      da_q[15:8] <= frame_byte_i;
        udpip_pkg::POS_DA3:      da_q[7:0] <= frame_byte_i;
        default: ;
      endcase
    end
    if (acc_i && udp_hit) begin
      udp_q[rel[2:0]] <= frame_byte_i;
    end
  end

  // classification on the final byte, all needed bytes already captured
  always_comb begin
    off_hdr = udpip_pkg::ETH_HDR_LEN + {1'b0, ihl_q, 2'b00};
    reject  = (len_next < udpip_pkg::MIN_FRAME_LEN) || (et_hi_q != udpip_pkg::ETYPE_HI) ||
              (et_lo_q != udpip_pkg::ETYPE_LO) || (proto_q != udpip_pkg::PROTO_UDP);
    trunc   = (16'(off_hdr) + 16'(udpip_pkg::UDP_HDR_LEN)) > len_next;
    push_o  = acc_i && last_byte_i;
    if (reject) begin
      rec_o.status = udpip_pkg::ST_REJECT;
    end else if (trunc) begin
      rec_o.status = udpip_pkg::ST_TRUNC;
    end else begin
      rec_o.status = udpip_pkg::ST_ACCEPT;
    end
    rec_o.src_addr = sa_q;
    rec_o.dst_addr = da_q;
    rec_o.src_port = {udp_q[0], udp_q[1]};
    rec_o.dst_port = {udp_q[2], udp_q[3]};
    rec_o.udp_len  = {udp_q[4], udp_q[5]};
    rec_o.pay_off  = off_hdr + udpip_pkg::UDP_HDR_LEN;
  end

endmodule

// File: design/udpip_queue.sv
`include "udp_ipv4_header_parser_defines.svh"

module udpip_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  udpip_pkg::rec_t   rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              avail_o,
  output udpip_pkg::rec_t   rec_o
);

  udpip_pkg::rec_t entry_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      level_q;

  assign full_o  = level_q == 2'd2;
  assign avail_o = level_q != 2'd0;
  assign rec_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 2'd1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= rec_i;
    end
  end

  `UDP_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `UDP_ASSERT_NEVER(a_no_underflow, pop_i && !avail_o, "pop from empty queue")
  `UDP_ASSERT(a_push_lands, push_i |=> avail_o, "pushed result missing from queue")

endmodule

// File: design/udpip_back.sv
module udpip_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  udpip_pkg::rec_t   rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [31:0]       source_address_o,
  output logic [31:0]       dest_address_o,
  output logic [15:0]       source_port_o,
  output logic [15:0]       dest_port_o,
  output logic [6:0]        payload_offset_o,
  output logic [15:0]       payload_length_o,
  output logic              same_address_o
);

  logic        valid_q;
  logic        ok;
  logic [1:0]  status_q;
  logic [31:0] sa_q, da_q;
  logic [15:0] sp_q, dp_q, plen_q, plen_d;
  logic [6:0]  off_q;
  logic        same_q;

  assign pop_o = avail_i && (!valid_q || !out_stall_i);
  assign ok    = rec_i.status == udpip_pkg::ST_ACCEPT;

  // udp length minus header, clamped at zero
  assign plen_d = (rec_i.udp_len >= 16'(udpip_pkg::UDP_HDR_LEN)) ?
                  rec_i.udp_len - 16'(udpip_pkg::UDP_HDR_LEN) : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= rec_i.status;
      sa_q     <= ok ? rec_i.src_addr : 32'd0;
      da_q     <= ok ? rec_i.dst_addr : 32'd0;
      sp_q     <= ok ? rec_i.src_port : 16'd0;
      dp_q     <= ok ? rec_i.dst_port : 16'd0;
      off_q    <= ok ? rec_i.pay_off : 7'd0;
      plen_q   <= ok ? plen_d : 16'd0;
      same_q   <= ok && (rec_i.src_addr == rec_i.dst_addr);
    end
  end

  assign out_valid_o      = valid_q;
  assign status_o         = status_q;
  assign source_address_o = sa_q;
  assign dest_address_o   = da_q;
  assign source_port_o    = sp_q;
  assign dest_port_o      = dp_q;
  assign payload_offset_o = off_q;
  assign payload_length_o = plen_q;
  assign same_address_o   = same_q;

endmodule

// File: design/udp_ipv4_header_parser.sv
// a result passes through the result queue and then the output register after its frame's last byte is accepted
// throughput: one byte per cycle; the front only stalls while its two-entry
//   result queue is full, i.e. two results queued behind a stalled output
// reset: asynchronous, active low; clears the byte count, queue and output valid
// captured header bytes are not reset; results never depend on unwritten ones
`include "udp_ipv4_header_parser_defines.svh"

module udp_ipv4_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [6:0]  payload_offset_o,
  output logic [15:0] payload_length_o,
  output logic        same_address_o
);

  logic            in_acc;
  logic            push, full, pop, avail;
  udpip_pkg::rec_t front_rec, queue_rec;
  logic            fields_zero, off_in_range;

  // a byte is taken whenever there is room for a possible result
  assign in_stall_o = full;
  assign in_acc     = in_valid_i && !in_stall_o;

  // front: counts bytes, captures header fields, classifies on the last byte
  udpip_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .push_o       (push),
    .rec_o        (front_rec)
  );

  // short queue decouples the byte stream from output back-pressure
  udpip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .rec_o   (queue_rec)
  );

  // back: payload length, address compare, field masking and output register
  udpip_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (avail),
    .rec_i            (queue_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .source_address_o (source_address_o),
    .dest_address_o   (dest_address_o),
    .source_port_o    (source_port_o),
    .dest_port_o      (dest_port_o),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o),
    .same_address_o   (same_address_o)
  );

  // every field but status is zero
  assign fields_zero  = (source_address_o == 32'd0) && (dest_address_o == 32'd0) &&
                        (source_port_o == 16'd0) && (dest_port_o == 16'd0) &&
                        (payload_offset_o == 7'd0) && (payload_length_o == 16'd0) &&
                        !same_address_o;
  assign off_in_range = (payload_offset_o >= 7'd22) && (payload_offset_o <= 7'd82);

  // non-accepted results carry only a status
  `UDP_ASSERT(a_reject_zero, out_valid_o && (status_o != udpip_pkg::ST_ACCEPT) |-> fields_zero, "rejected result has nonzero fields")
  // accepted payload offset lies between 22 and 82
  `UDP_ASSERT(a_offset_range, out_valid_o && (status_o == udpip_pkg::ST_ACCEPT) |-> off_in_range, "payload offset out of range")
  // a fresh result is always preceded by an entry waiting in the result queue
  `UDP_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(avail), "result without queued entry")

endmodule
